// ===== design/opoly_pkg.sv =====
package opoly_pkg;

    // field widths fixed by the interface
    localparam int ORDER_W = 5;

    // polynomial family codes
    localparam logic [1:0] FAM_LEGENDRE  = 2'd0;
    localparam logic [1:0] FAM_HERMITE   = 2'd1;
    localparam logic [1:0] FAM_CHEBYSHEV = 2'd2;
    localparam logic [1:0] FAM_NONE      = 2'd3;

    // q32.32 constants
    localparam logic signed [63:0] ONE_Q32 = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] VAL_MIN = 64'sh8000_0000_0000_0000;

    // divider: quotient bits retired per cycle
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = 64 / DIV_BITS;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // post-scaling of the multiplier product
    // SC_INT: exact integer product, SC_X2: round(p*x/2^27), SC_X: round(p*x/2^28)
    typedef enum logic [1:0] {
        SC_INT,
        SC_X2,
        SC_X
    } scale_t;

    typedef enum logic [2:0] {
        MP_IDLE,
        MP_LO,
        MP_HI,
        MP_SUM,
        MP_FIN
    } mul_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOP,
        ST_MX,
        ST_MKA,
        ST_MKB,
        ST_SUB,
        ST_DIV,
        ST_DONE
    } state_t;

    // request to the shared multiplier: magnitude times small unsigned factor
    typedef struct packed {
        logic [63:0] mag;
        logic [31:0] mult;
        logic        neg;
        scale_t      scale;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] value;
        logic               sat;
        logic               neg;
    } mul_res_t;

    typedef struct packed {
        logic               done;
        logic signed [63:0] value;
    } div_res_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - unsigned'(v)) : unsigned'(v);
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? (32'd0 - unsigned'(v)) : unsigned'(v);
    endfunction

endpackage

// ===== design/opoly_mul.sv =====
module opoly_mul (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  opoly_pkg::mul_req_t req,
    output opoly_pkg::mul_res_t res
);
    import opoly_pkg::*;

    mul_phase_t  ph_reg, ph_next;
    logic [63:0] ma_reg, ma_next;
    logic [31:0] mb_reg, mb_next;
    logic        neg_reg, neg_next;
    scale_t      sc_reg, sc_next;
    logic [63:0] plo_reg, plo_next;
    logic [63:0] phi_reg, phi_next;
    logic [95:0] t_reg, t_next;
    logic        done_reg, done_next;
    logic [63:0] val_reg, val_next;
    logic        sat_reg, sat_next;

    logic [31:0] mul_a;
    logic [63:0] prod;
    logic [63:0] half;
    logic [95:0] r;
    logic [32:0] r_top;

    // single 32x32 multiplier, low half of the magnitude first
    assign mul_a = (ph_reg == MP_HI) ? ma_reg[63:32] : ma_reg[31:0];
    assign prod  = mul_a * mb_reg;

    // rounding constant, ties away from zero on the magnitude
    always_comb begin
        case (sc_reg)
            SC_X:    half = 64'd1 << 27;
            SC_X2:   half = 64'd1 << 26;
            default: half = 64'd0;
        endcase
    end

    // scale back to q32.32
    always_comb begin
        case (sc_reg)
            SC_X:    r = t_reg >> 28;
            SC_X2:   r = t_reg >> 27;
            default: r = t_reg;
        endcase
    end

    assign r_top = r[95:63];

    // phase sequencer
    always_comb begin
        ph_next   = ph_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        sc_next   = sc_reg;
        plo_next  = plo_reg;
        phi_next  = phi_reg;
        t_next    = t_reg;
        val_next  = val_reg;
        sat_next  = sat_reg;
        done_next = 1'b0;

        unique case (ph_reg)
            MP_IDLE: begin
            end
            MP_LO: begin
                plo_next = prod;
                ph_next  = MP_HI;
            end
            MP_HI: begin
                phi_next = prod;
                plo_next = plo_reg + half;
                ph_next  = MP_SUM;
            end
            MP_SUM: begin
                t_next  = {phi_reg, 32'd0} + {32'd0, plo_reg};
                ph_next = MP_FIN;
            end
            MP_FIN: begin
                // beyond the signed range, except exactly 2^63 when negative
                sat_next  = (|r_top) && !(neg_reg && (r_top == 33'd1) && (r[62:0] == '0));
                val_next  = neg_reg ? (64'd0 - r[63:0]) : r[63:0];
                done_next = 1'b1;
                ph_next   = MP_IDLE;
            end
            default: ph_next = MP_IDLE;
        endcase

        if (start) begin
            ma_next  = req.mag;
            mb_next  = req.mult;
            neg_next = req.neg;
            sc_next  = req.scale;
            ph_next  = MP_LO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ph_reg   <= MP_IDLE;
            done_reg <= 1'b0;
        end else begin
            ph_reg   <= ph_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        ma_reg  <= ma_next;
        mb_reg  <= mb_next;
        neg_reg <= neg_next;
        sc_reg  <= sc_next;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        t_reg   <= t_next;
        val_reg <= val_next;
        sat_reg <= sat_next;
    end

    assign res.done  = done_reg;
    assign res.value = val_reg;
    assign res.sat   = sat_reg;
    assign res.neg   = neg_reg;

endmodule

// ===== design/opoly_div.sv =====
module opoly_div #(
    parameter int KW = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic signed [63:0]  dividend,
    input  logic [KW-1:0]       divisor,
    output opoly_pkg::div_res_t res
);
    import opoly_pkg::*;

    logic              busy_reg, busy_next;
    logic              fin_reg, fin_next;
    logic              neg_reg, neg_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [63:0]       dq_reg, dq_next;
    logic [KW-1:0]     rem_reg, rem_next;
    logic [KW-1:0]     dv_reg, dv_next;

    logic [63:0] opa;
    logic [63:0] opb;
    logic [63:0] q;
    logic [KW:0] rs;
    logic [KW-1:0] r;
    logic [63:0] qneg;

    // magnitude plus half the divisor in one add
    assign opa = dividend[63] ? ~unsigned'(dividend) : unsigned'(dividend);
    assign opb = 64'(divisor >> 1) + 64'(dividend[63]);

    always_comb begin
        busy_next = busy_reg;
        fin_next  = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dv_next   = dv_reg;

        // restoring division, several quotient bits per cycle
        q  = dq_reg;
        r  = rem_reg;
        rs = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            rs = {r, q[63]};
            q  = {q[62:0], 1'b0};
            if (rs >= {1'b0, dv_reg}) begin
                rs   = rs - {1'b0, dv_reg};
                q[0] = 1'b1;
            end
            r = rs[KW-1:0];
        end

        if (start) begin
            neg_next  = dividend[63];
            dq_next   = opa + opb;
            rem_next  = '0;
            dv_next   = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dq_next  = q;
            rem_next = r;
            cnt_next = cnt_reg + DIV_CW'(1);
            if (cnt_reg == DIV_CW'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg <= neg_next;
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dv_reg  <= dv_next;
    end

    // restore the sign of the quotient
    assign qneg      = 64'd0 - dq_reg;
    assign res.done  = fin_reg;
    assign res.value = neg_reg ? qneg : dq_reg;

endmodule

// ===== design/orthogonal_polynomial_eval.sv =====
// orders 0 and 1 need no recurrence step; a higher order n runs n-1 recurrence steps
// each recurrence step is set by the shared 32x32 multiplier and, for Legendre, the divider
//   retiring 8 quotient bits a cycle
// one request at a time; s_ready returns with the result in the output register
// reset: synchronous active-low aresetn idles the sequencer and empties the output
module orthogonal_polynomial_eval #(
    parameter int MAX_ORDER = 31
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_req_type,
    input  logic [opoly_pkg::ORDER_W-1:0]   s_order,
    input  logic signed [31:0]              s_point,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [63:0]              m_value,
    output logic                            m_overflow
);
    import opoly_pkg::*;

    localparam int ORDER_TOP = (1 << ORDER_W) - 1;
    localparam int N_MAX     = (MAX_ORDER < ORDER_TOP) ? MAX_ORDER : ORDER_TOP;
    localparam int KW        = (N_MAX < 2) ? 2 : $clog2(N_MAX + 1);

    state_t             state_reg, state_next;
    logic [1:0]         fam_reg, fam_next;
    logic [KW-1:0]      n_reg, n_next;
    logic [KW-1:0]      k_reg, k_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [63:0] p0_reg, p0_next;
    logic signed [63:0] p1_reg, p1_next;
    logic signed [63:0] a_reg, a_next;
    logic signed [63:0] b_reg, b_next;
    logic               sat_reg, sat_next;
    logic               satneg_reg, satneg_next;
    logic               m_valid_reg, m_valid_next;
    logic signed [63:0] m_value_reg, m_value_next;
    logic               m_overflow_reg, m_overflow_next;

    logic     mul_start;
    mul_req_t mul_req;
    mul_res_t mul_res;
    logic     div_start;
    div_res_t div_res;

    logic signed [63:0] x_ext;
    logic signed [64:0] diff;
    logic [KW-1:0]      k_less;
    logic [KW:0]        coef_odd;
    logic               out_free;
    logic               adv;
    logic signed [63:0] cur;

    assign x_ext    = {{32{s_point[31]}}, s_point};
    assign diff     = {a_reg[63], a_reg} - {b_reg[63], b_reg};
    assign k_less   = k_reg - KW'(1);
    assign coef_odd = {k_reg, 1'b0} - (KW + 1)'(1);
    assign out_free = !m_valid_reg || m_ready;

    // shared multiplier and divider
    opoly_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .req     (mul_req),
        .res     (mul_res)
    );

    opoly_div #(
        .KW (KW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (diff[63:0]),
        .divisor  (k_reg),
        .res      (div_res)
    );

    // recurrence sequencer
    always_comb begin
        state_next      = state_reg;
        fam_next        = fam_reg;
        n_next          = n_reg;
        k_next          = k_reg;
        x_next          = x_reg;
        p0_next         = p0_reg;
        p1_next         = p1_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        sat_next        = sat_reg;
        satneg_next     = satneg_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_value_next    = m_value_reg;
        m_overflow_next = m_overflow_reg;
        div_start       = 1'b0;
        adv             = 1'b0;
        cur             = diff[63:0];

        // default request: x times p1, rescaled
        mul_start     = 1'b0;
        mul_req.mag   = mag64(p1_reg);
        mul_req.mult  = mag32(x_reg);
        mul_req.neg   = p1_reg[63] ^ x_reg[31];
        mul_req.scale = (fam_reg == FAM_LEGENDRE) ? SC_X : SC_X2;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    fam_next    = s_req_type;
                    n_next      = (int'(s_order) > N_MAX) ? KW'(N_MAX) : KW'(s_order);
                    k_next      = KW'(2);
                    x_next      = s_point;
                    p0_next     = ONE_Q32;
                    sat_next    = 1'b0;
                    satneg_next = 1'b0;
                    if (s_req_type == FAM_NONE) begin
                        p1_next = '0;
                    end else if (s_order == '0) begin
                        p1_next = ONE_Q32;
                    end else if (s_req_type == FAM_HERMITE) begin
                        p1_next = x_ext <<< 5;
                    end else begin
                        p1_next = x_ext <<< 4;
                    end
                    state_next = ST_LOOP;
                end
            end
            ST_LOOP: begin
                if (fam_reg == FAM_NONE || n_reg < KW'(2)) begin
                    state_next = ST_DONE;
                end else begin
                    mul_start  = 1'b1;
                    state_next = ST_MX;
                end
            end
            ST_MX: begin
                if (mul_res.done) begin
                    if (mul_res.sat) begin
                        sat_next    = 1'b1;
                        satneg_next = mul_res.neg;
                        state_next  = ST_DONE;
                    end else begin
                        a_next = mul_res.value;
                        case (fam_reg)
                            FAM_LEGENDRE: begin
                                mul_start     = 1'b1;
                                mul_req.mag   = mag64(mul_res.value);
                                mul_req.mult  = 32'(coef_odd);
                                mul_req.neg   = mul_res.value[63];
                                mul_req.scale = SC_INT;
                                state_next    = ST_MKA;
                            end
                            FAM_HERMITE: begin
                                mul_start     = 1'b1;
                                mul_req.mag   = mag64(p0_reg);
                                mul_req.mult  = 32'({k_less, 1'b0});
                                mul_req.neg   = p0_reg[63];
                                mul_req.scale = SC_INT;
                                state_next    = ST_MKB;
                            end
                            default: begin
                                b_next     = p0_reg;
                                state_next = ST_SUB;
                            end
                        endcase
                    end
                end
            end
            ST_MKA: begin
                if (mul_res.done) begin
                    if (mul_res.sat) begin
                        sat_next    = 1'b1;
                        satneg_next = mul_res.neg;
                        state_next  = ST_DONE;
                    end else begin
                        a_next        = mul_res.value;
                        mul_start     = 1'b1;
                        mul_req.mag   = mag64(p0_reg);
                        mul_req.mult  = 32'(k_less);
                        mul_req.neg   = p0_reg[63];
                        mul_req.scale = SC_INT;
                        state_next    = ST_MKB;
                    end
                end
            end
            ST_MKB: begin
                if (mul_res.done) begin
                    if (mul_res.sat) begin
                        sat_next    = 1'b1;
                        satneg_next = mul_res.neg;
                        state_next  = ST_DONE;
                    end else begin
                        b_next     = mul_res.value;
                        state_next = ST_SUB;
                    end
                end
            end
            ST_SUB: begin
                // overflow only when the operand signs differ; sign follows a
                if (diff[64] != diff[63]) begin
                    sat_next    = 1'b1;
                    satneg_next = a_reg[63];
                    state_next  = ST_DONE;
                end else if (fam_reg == FAM_LEGENDRE) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    adv = 1'b1;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    cur = div_res.value;
                    adv = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_value_next    = sat_reg ? (satneg_reg ? VAL_MIN : VAL_MAX) : p1_reg;
                    m_overflow_next = sat_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // shift the recurrence and move to the next order
        if (adv) begin
            p0_next = p1_reg;
            p1_next = cur;
            if (k_reg == n_reg) begin
                state_next = ST_DONE;
            end else begin
                k_next     = k_reg + KW'(1);
                state_next = ST_LOOP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fam_reg        <= fam_next;
        n_reg          <= n_next;
        k_reg          <= k_next;
        x_reg          <= x_next;
        p0_reg         <= p0_next;
        p1_reg         <= p1_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        sat_reg        <= sat_next;
        satneg_reg     <= satneg_next;
        m_value_reg    <= m_value_next;
        m_overflow_reg <= m_overflow_next;
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_value    = m_value_reg;
    assign m_overflow = m_overflow_reg;

endmodule

// ===== design/opoly_chk.sv =====
module opoly_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [63:0] m_value,
    input logic               m_overflow
);
    import opoly_pkg::*;

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value) && $stable(m_overflow))
        else $error("result beat changed while stalled");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again straight after a beat");

    // a new result is only loaded while the sequencer is busy
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared while idle");

    // overflow always comes with a saturated value
    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> (m_value == VAL_MAX) || (m_value == VAL_MIN))
        else $error("overflow flagged without saturated value");

endmodule

bind orthogonal_polynomial_eval opoly_chk u_opoly_chk (.*);
